// ===== hw/rtl/sfd_pkg.sv =====
package sfd_pkg;

    // Frame layout
    localparam int unsigned FRAME_LEN  = 25;
    localparam int unsigned STORE_LEN  = 24;
    localparam int unsigned NUM_PROP   = 16;
    localparam int unsigned CHAN_BITS  = 11;

    // Width of the wrapping error and lost counters
    localparam int unsigned COUNT_BITS = 16;

    // Configuration register indexes
    localparam logic [1:0] REG_START_BYTE = 2'd0;
    localparam logic [1:0] REG_END_BYTE   = 2'd1;

    // Result kinds
    localparam logic [1:0] KIND_CHANNEL   = 2'd0;
    localparam logic [1:0] KIND_START_ERR = 2'd1;
    localparam logic [1:0] KIND_END_ERR   = 2'd2;

    // Position of flag bits in byte 23
    localparam int unsigned FLAG_DIG1     = 0;
    localparam int unsigned FLAG_DIG2     = 1;
    localparam int unsigned FLAG_LOST     = 2;
    localparam int unsigned FLAG_FAILSAFE = 3;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FETCH = 5'b00010,
        ST_MERGE = 5'b00100,
        ST_EMIT  = 5'b01000,
        ST_HOLD  = 5'b10000
    } state_t;

endpackage

// ===== hw/rtl/sbus_frame_decoder.sv =====
// An error result is registered: it is valid in the cycle after the offending byte is taken.
// Bytes 0 to 23 of a frame are taken one per cycle while no result is pending;
//   byte 24 of a good frame keeps the block busy while it reads stored bytes 1 to 22
//   (22 reads through the single store read port) and hands out its 18 results.
// Reset (rst_n low, async): control, counters and failsafe clear, start_byte=15,
//   end_byte=0; the frame store is not cleared and needs no clearing pass.
module sbus_frame_decoder (
    input  logic               clk,
    input  logic               rst_n,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    // received byte channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         result_kind,
    output logic [4:0]         channel_number,
    output logic signed [10:0] channel_value,
    output logic               failsafe_state,
    output logic               frame_lost_flag,
    output logic [15:0]        error_frames,
    output logic [15:0]        lost_frames,
    output logic               last_of_frame
);

    // Control and status state
    sfd_pkg::state_t                   state_reg, state_next;
    logic [4:0]                        pos_reg, pos_next;
    logic [sfd_pkg::COUNT_BITS-1:0]    err_cnt_reg, err_cnt_next;
    logic [sfd_pkg::COUNT_BITS-1:0]    lost_cnt_reg, lost_cnt_next;
    logic                              failsafe_reg, failsafe_next;
    logic [7:0]                        start_byte_reg, end_byte_reg;

    // Unpack sequencer: byte read address, bit buffer and channel counter
    logic [4:0]                        rd_addr_reg, rd_addr_next;
    logic [7:0]                        rd_data_reg;
    logic [17:0]                       acc_reg, acc_next;
    logic [4:0]                        cnt_reg, cnt_next;
    logic [4:0]                        chan_reg, chan_next;
    logic [7:0]                        flags_reg, flags_next;

    // Output register
    logic                              out_valid_reg, out_valid_next;
    logic [1:0]                        out_kind_reg, out_kind_next;
    logic [4:0]                        out_num_reg, out_num_next;
    logic [10:0]                       out_val_reg, out_val_next;
    logic                              out_lost_reg, out_lost_next;
    logic                              out_last_reg, out_last_next;

    // Frame store, bytes 0 to 23
    logic [7:0]                        store_mem [sfd_pkg::STORE_LEN];
    logic                              store_we;
    logic [4:0]                        store_waddr;

    logic                              in_fire;
    logic                              out_fire;
    logic                              dig_bit;

    assign in_ready  = (state_reg == sfd_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= 8'd15;
            end_byte_reg   <= 8'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sfd_pkg::REG_START_BYTE: start_byte_reg <= cfg_data;
                sfd_pkg::REG_END_BYTE:   end_byte_reg   <= cfg_data;
                default:
                begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    // Store: one write port from the byte channel, one registered read port
    // for the unpacker. Writes and reads never overlap in time.
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[store_waddr] <= rx_byte;
        end
        rd_data_reg <= store_mem[rd_addr_reg];
    end

    // Digital channel 17 takes flag bit 0, channel 18 flag bit 1
    assign dig_bit = (chan_reg[0] == 1'b0) ? flags_reg[sfd_pkg::FLAG_DIG1]
                                           : flags_reg[sfd_pkg::FLAG_DIG2];

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        err_cnt_next   = err_cnt_reg;
        lost_cnt_next  = lost_cnt_reg;
        failsafe_next  = failsafe_reg;
        rd_addr_next   = rd_addr_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        chan_next      = chan_reg;
        flags_next     = flags_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_num_next   = out_num_reg;
        out_val_next   = out_val_reg;
        out_lost_next  = out_lost_reg;
        out_last_next  = out_last_reg;
        store_we       = 1'b0;
        store_waddr    = pos_reg;

        unique case (state_reg)
            sfd_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if ((pos_reg == 5'd0) && (rx_byte != start_byte_reg))
                    begin
                        // sync error: drop the byte, stay at position 0
                        err_cnt_next   = err_cnt_reg + 1'b1;
                        out_valid_next = 1'b1;
                        out_kind_next  = sfd_pkg::KIND_START_ERR;
                        out_num_next   = 5'd0;
                        out_val_next   = 11'd0;
                        out_lost_next  = 1'b0;
                        out_last_next  = 1'b1;
                        state_next     = sfd_pkg::ST_HOLD;
                    end
                    else if (pos_reg < 5'(sfd_pkg::STORE_LEN))
                    begin
                        store_we = 1'b1;
                        if (pos_reg == 5'(sfd_pkg::STORE_LEN - 1))
                        begin
                            flags_next = rx_byte;
                        end
                        pos_next = pos_reg + 1'b1;
                    end
                    else
                    begin
                        pos_next = 5'd0;
                        if (rx_byte != end_byte_reg)
                        begin
                            err_cnt_next   = err_cnt_reg + 1'b1;
                            out_valid_next = 1'b1;
                            out_kind_next  = sfd_pkg::KIND_END_ERR;
                            out_num_next   = 5'd0;
                            out_val_next   = 11'd0;
                            out_lost_next  = 1'b0;
                            out_last_next  = 1'b1;
                            state_next     = sfd_pkg::ST_HOLD;
                        end
                        else
                        begin
                            // good frame: update flags, start unpacking at byte 1
                            failsafe_next = flags_reg[sfd_pkg::FLAG_FAILSAFE];
                            if (flags_reg[sfd_pkg::FLAG_LOST])
                            begin
                                lost_cnt_next = lost_cnt_reg + 1'b1;
                            end
                            rd_addr_next = 5'd1;
                            acc_next     = 18'd0;
                            cnt_next     = 5'd0;
                            chan_next    = 5'd0;
                            state_next   = sfd_pkg::ST_FETCH;
                        end
                    end
                end
            end

            sfd_pkg::ST_FETCH:
            begin
                // store read data lands in rd_data_reg this cycle
                state_next = sfd_pkg::ST_MERGE;
            end

            sfd_pkg::ST_MERGE:
            begin
                // append the byte above the bits still held (at most 10)
                acc_next     = acc_reg | (18'(rd_data_reg) << cnt_reg);
                cnt_next     = cnt_reg + 5'd8;
                rd_addr_next = rd_addr_reg + 1'b1;
                if (cnt_reg >= 5'd3)
                begin
                    state_next = sfd_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = sfd_pkg::ST_FETCH;
                end
            end

            sfd_pkg::ST_EMIT:
            begin
                out_valid_next = 1'b1;
                out_kind_next  = sfd_pkg::KIND_CHANNEL;
                out_num_next   = chan_reg + 1'b1;
                out_lost_next  = flags_reg[sfd_pkg::FLAG_LOST];
                if (chan_reg < 5'(sfd_pkg::NUM_PROP))
                begin
                    // raw minus 1024 is the raw value with its top bit flipped
                    out_val_next  = {~acc_reg[sfd_pkg::CHAN_BITS-1],
                                     acc_reg[sfd_pkg::CHAN_BITS-2:0]};
                    out_last_next = 1'b0;
                    acc_next      = acc_reg >> sfd_pkg::CHAN_BITS;
                    cnt_next      = cnt_reg - 5'(sfd_pkg::CHAN_BITS);
                end
                else
                begin
                    out_val_next  = dig_bit ? 11'h3FF : 11'h400;
                    out_last_next = (chan_reg == 5'(sfd_pkg::NUM_PROP + 1));
                end
                chan_next  = chan_reg + 1'b1;
                state_next = sfd_pkg::ST_HOLD;
            end

            sfd_pkg::ST_HOLD:
            begin
                if (out_fire)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        state_next = sfd_pkg::ST_IDLE;
                    end
                    else if ((chan_reg >= 5'(sfd_pkg::NUM_PROP)) ||
                             (cnt_reg >= 5'(sfd_pkg::CHAN_BITS)))
                    begin
                        state_next = sfd_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = sfd_pkg::ST_FETCH;
                    end
                end
            end

            default:
            begin
                state_next = sfd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sfd_pkg::ST_IDLE;
            pos_reg       <= 5'd0;
            err_cnt_reg   <= '0;
            lost_cnt_reg  <= '0;
            failsafe_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rd_addr_reg   <= 5'd0;
            cnt_reg       <= 5'd0;
            chan_reg      <= 5'd0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            err_cnt_reg   <= err_cnt_next;
            lost_cnt_reg  <= lost_cnt_next;
            failsafe_reg  <= failsafe_next;
            out_valid_reg <= out_valid_next;
            rd_addr_reg   <= rd_addr_next;
            cnt_reg       <= cnt_next;
            chan_reg      <= chan_next;
            out_last_reg  <= out_last_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        flags_reg    <= flags_next;
        out_kind_reg <= out_kind_next;
        out_num_reg  <= out_num_next;
        out_val_reg  <= out_val_next;
        out_lost_reg <= out_lost_next;
    end

    assign out_valid       = out_valid_reg;
    assign result_kind     = out_kind_reg;
    assign channel_number  = out_num_reg;
    assign channel_value   = out_val_reg;
    assign frame_lost_flag = out_lost_reg;
    assign last_of_frame   = out_last_reg;
    // counters and failsafe only move while no result is pending
    assign failsafe_state  = failsafe_reg;
    assign error_frames    = 16'(err_cnt_reg);
    assign lost_frames     = 16'(lost_cnt_reg);

    // A pending result always blocks new bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !in_ready)
        else $error("byte channel open while a result is pending");

    // Unpacking never touches the counters
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sfd_pkg::ST_FETCH || state_reg == sfd_pkg::ST_MERGE)
        |=> $stable(err_cnt_reg) && $stable(lost_cnt_reg))
        else $error("counter moved during unpack");

    // The last channel result of a frame is channel 18
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg && out_kind_reg == sfd_pkg::KIND_CHANNEL)
        |-> out_num_reg == 5'(sfd_pkg::NUM_PROP + 2))
        else $error("frame closed on wrong channel");

    // Frame position stays inside the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= 5'(sfd_pkg::FRAME_LEN - 1))
        else $error("byte position out of range");

endmodule
